FILE: rtl/ppx_pkg.sv
// shared types and constants of the pulse peak pedestal extractor
`timescale 1ns / 1ps
`default_nettype none
package ppx_pkg;

  localparam int unsigned SampleW     = 10;
  localparam int unsigned TimeW       = 10;
  localparam int unsigned ModuleW     = 3;
  localparam int unsigned RowW        = 6;
  localparam int unsigned ColumnW     = 6;
  localparam int unsigned FracW       = 8;
  localparam int unsigned MaxTimeBins = 1024;
  localparam int unsigned CountW      = $clog2(MaxTimeBins) + 1;
  localparam int unsigned SumW        = SampleW + $clog2(MaxTimeBins);
  localparam int unsigned DividendW   = SumW + FracW;
  localparam int unsigned StepW       = $clog2(DividendW);
  localparam int unsigned PeakQW      = SampleW + FracW;
  localparam int unsigned GainW       = 7;
  localparam int unsigned ProductW    = PeakQW + GainW;
  localparam int unsigned BaselineW   = 19;
  localparam int unsigned EnergyW     = 22;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 19;

  localparam logic [EnergyW-1:0] EnergyMax = {EnergyW{1'b1}};
  localparam logic [CountW-1:0]  CountCap  = CountW'(MaxTimeBins);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PED_ENABLE     = 2'd0,
    CFG_PRESAMPLE_LIM  = 2'd1,
    CFG_LOW_GAIN_FACT  = 2'd2,
    CFG_BASELINE       = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/ppx_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ppx_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ppx_pkg::DividendW-1:0]    dividend_i,
  input  logic [ppx_pkg::CountW-1:0]       divisor_i,
  output logic [ppx_pkg::DividendW-1:0]    quotient_o,
  output ppx_pkg::div_stat_t               stat_o
);
  import ppx_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DividendW-1:0] dq_q, dq_d;
  logic [CountW-1:0]    rem_q, rem_d;
  logic [CountW-1:0]    dvs_q, dvs_d;
  logic [CountW:0]      rem_shift;
  logic [CountW:0]      rem_diff;
  logic                 q_bit;

  // one restoring step: shift in next dividend bit, try subtract
  assign rem_shift = {rem_q, dq_q[DividendW-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign q_bit     = (rem_shift >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[DividendW-2:0], q_bit};
      rem_d = q_bit ? rem_diff[CountW-1:0] : rem_shift[CountW-1:0];
      if (step_q == StepW'(DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = dq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

FILE: rtl/pulse_peak_pedestal_extractor_top.sv
// top level: channel tracking, report sequencer and output register
// report path: a sample that closes a channel yields its word after the divider
//   run (only with pedestal subtraction), one mean load, one energy step and one
//   output load
// throughput: one sample per cycle while no channel closes; a closing sample
//   holds the input until its word enters the output register, through the
//   bit-serial divider run with pedestal subtraction and while the output stalls
// reset: asynchronous active low; clears channel state, output valid and the
//   registers to 0, 10, 16 and 256
`timescale 1ns / 1ps
`default_nettype none
module pulse_peak_pedestal_extractor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppx_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [ppx_pkg::CfgDataW-1:0]      cfg_data_i,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ppx_pkg::SampleW-1:0]       sample_value_i,
  input  logic [ppx_pkg::TimeW-1:0]         time_bin_i,
  input  logic                              starts_channel_i,
  input  logic                              low_gain_i,
  input  logic [ppx_pkg::ModuleW-1:0]       module_index_i,
  input  logic [ppx_pkg::RowW-1:0]          row_index_i,
  input  logic [ppx_pkg::ColumnW-1:0]       column_index_i,
  // report channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ppx_pkg::EnergyW-1:0]       energy_q8_o,
  output logic [ppx_pkg::TimeW-1:0]         report_time_bin_o,
  output logic                              report_low_gain_o,
  output logic [ppx_pkg::ModuleW:0]         report_module_o,
  output logic [ppx_pkg::RowW:0]            report_row_o,
  output logic [ppx_pkg::ColumnW:0]         report_column_o,
  output logic                              status_o
);
  import ppx_pkg::*;

  // configuration registers
  logic                 ped_en_q;
  logic [TimeW-1:0]     presample_lim_q;
  logic [GainW-1:0]     gain_fact_q;
  logic [BaselineW-1:0] baseline_q;

  // running channel state
  logic                 has_samples_q;
  logic [SampleW-1:0]   peak_q;
  logic [SumW-1:0]      ped_sum_q;
  logic [CountW-1:0]    ped_cnt_q;
  logic [TimeW-1:0]     held_time_q;
  logic                 held_gain_q;
  logic [ModuleW-1:0]   held_module_q;
  logic [RowW-1:0]      held_row_q;
  logic [ColumnW-1:0]   held_column_q;

  // snapshot of the channel being reported
  logic [SampleW-1:0]   rep_peak_q;
  logic                 rep_status_q;
  logic [TimeW-1:0]     rep_time_q;
  logic                 rep_gain_q;
  logic [ModuleW-1:0]   rep_module_q;
  logic [RowW-1:0]      rep_row_q;
  logic [ColumnW-1:0]   rep_column_q;

  logic [PeakQW-1:0]    mean_q;
  logic [ProductW-1:0]  energy_raw_q;

  // output register
  logic                 out_valid_q;
  logic [EnergyW-1:0]   out_energy_q;
  logic [TimeW-1:0]     out_time_q;
  logic                 out_gain_q;
  logic [ModuleW:0]     out_module_q;
  logic [RowW:0]        out_row_q;
  logic [ColumnW:0]     out_column_q;
  logic                 out_status_q;

  seq_state_e state_q, state_d;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 closes_chan;
  logic                 opens_chan;
  logic                 is_presample;
  logic                 need_div;
  logic                 div_start;
  logic                 out_load;
  logic                 out_free;
  logic [DividendW-1:0] div_quot;
  div_stat_t            div_stat;
  logic [SumW-1:0]      sum_base;
  logic [CountW-1:0]    cnt_base;
  logic [PeakQW-1:0]    peak_scaled;
  logic [PeakQW-1:0]    diff;
  logic [GainW-1:0]     mult;
  logic [EnergyW-1:0]   energy_final;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // a flagged sample closes the held channel; any sample opens one if none held
  assign closes_chan = starts_channel_i && has_samples_q;
  assign opens_chan  = starts_channel_i || !has_samples_q;
  // divide only when pedestal mode has presamples to average
  assign need_div    = ped_en_q && (ped_cnt_q != '0);
  assign div_start   = in_fire && closes_chan && need_div;

  // pedestal accumulation, count capped so repeated bins cannot overflow
  assign sum_base     = opens_chan ? '0 : ped_sum_q;
  assign cnt_base     = opens_chan ? '0 : ped_cnt_q;
  assign is_presample = ped_en_q && (time_bin_i < presample_lim_q) && (cnt_base < CountCap);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_en_q        <= 1'b0;
      presample_lim_q <= TimeW'(10);
      gain_fact_q     <= GainW'(16);
      baseline_q      <= BaselineW'(256);
    end else if (cfg_fire) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_PED_ENABLE:    ped_en_q        <= cfg_data_i[0];
        CFG_PRESAMPLE_LIM: presample_lim_q <= cfg_data_i[TimeW-1:0];
        CFG_LOW_GAIN_FACT: gain_fact_q     <= cfg_data_i[GainW-1:0];
        CFG_BASELINE:      baseline_q      <= cfg_data_i[BaselineW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- channel tracking ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_samples_q <= 1'b0;
      peak_q        <= '0;
      ped_sum_q     <= '0;
      ped_cnt_q     <= '0;
      held_time_q   <= '0;
      held_gain_q   <= 1'b0;
      held_module_q <= '0;
      held_row_q    <= '0;
      held_column_q <= '0;
    end else if (in_fire) begin
      has_samples_q <= 1'b1;
      if (opens_chan || (sample_value_i > peak_q)) begin
        peak_q <= sample_value_i;
      end
      ped_sum_q     <= is_presample ? sum_base + SumW'(sample_value_i) : sum_base;
      ped_cnt_q     <= is_presample ? cnt_base + CountW'(1) : cnt_base;
      held_time_q   <= time_bin_i;
      held_gain_q   <= low_gain_i;
      held_module_q <= module_index_i;
      held_row_q    <= row_index_i;
      held_column_q <= column_index_i;
    end
  end

  // snapshot taken from the held state before the new sample lands
  always_ff @(posedge clk_i) begin
    if (in_fire && closes_chan) begin
      rep_peak_q   <= peak_q;
      rep_status_q <= ped_en_q && (ped_cnt_q == '0);
      rep_time_q   <= held_time_q;
      rep_gain_q   <= held_gain_q;
      rep_module_q <= held_module_q;
      rep_row_q    <= held_row_q;
      rep_column_q <= held_column_q;
    end
  end

  // ---------------- shared divider: mean = (sum << 8) / count ----------------
  ppx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({ped_sum_q, {FracW{1'b0}}}),
    .divisor_i  (ped_cnt_q),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  // mean of samples never exceeds the peak range, so the low bits hold it
  always_ff @(posedge clk_i) begin
    if (in_fire && closes_chan && !need_div) begin
      mean_q <= '0;
    end else if (div_stat.done) begin
      mean_q <= div_quot[PeakQW-1:0];
    end
  end

  // ---------------- energy: subtract, gain scale, then threshold ----------------
  assign peak_scaled = {rep_peak_q, {FracW{1'b0}}};
  assign diff        = (mean_q > peak_scaled) ? '0 : peak_scaled - mean_q;
  assign mult        = rep_gain_q ? gain_fact_q : GainW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      energy_raw_q <= ProductW'(diff) * ProductW'(mult);
    end
  end

  always_comb begin
    if (rep_status_q) begin
      energy_final = '0;
    end else if (energy_raw_q < ProductW'(baseline_q)) begin
      energy_final = '0;
    end else if (energy_raw_q > ProductW'(EnergyMax)) begin
      energy_final = EnergyMax;
    end else begin
      energy_final = energy_raw_q[EnergyW-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && closes_chan) begin
          state_d = need_div ? ST_DIV : ST_CALC;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_energy_q <= energy_final;
      out_time_q   <= rep_time_q;
      out_gain_q   <= rep_gain_q;
      out_module_q <= {1'b0, rep_module_q} + (ModuleW+1)'(1);
      out_row_q    <= {1'b0, rep_row_q} + (RowW+1)'(1);
      out_column_q <= {1'b0, rep_column_q} + (ColumnW+1)'(1);
      out_status_q <= rep_status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign energy_q8_o       = out_energy_q;
  assign report_time_bin_o = out_time_q;
  assign report_low_gain_o = out_gain_q;
  assign report_module_o   = out_module_q;
  assign report_row_o      = out_row_q;
  assign report_column_o   = out_column_q;
  assign status_o          = out_status_q;

  // ---------------- assertions ----------------
  // divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside the divide state");

  // missing presamples always report zero energy
  a_status_zero_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (energy_q8_o == '0))
    else $error("error status word carries nonzero energy");

  // nonzero energy is never under the baseline
  a_energy_over_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (energy_q8_o != '0)) |-> (EnergyW'(baseline_q) <= energy_q8_o))
    else $error("reported energy below baseline");

  // a new report is loaded only once the previous word has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

endmodule
`default_nettype wire

FILE: tb/peak_report_checker.sv
// checker: predicts the extractor's channel reports from accepted words and compares them
`timescale 1ns / 1ps
module peak_report_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ppx_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ppx_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [ppx_pkg::SampleW-1:0]   sample_value_i,
  input  logic [ppx_pkg::TimeW-1:0]     time_bin_i,
  input  logic                          starts_channel_i,
  input  logic                          low_gain_i,
  input  logic [ppx_pkg::ModuleW-1:0]   module_index_i,
  input  logic [ppx_pkg::RowW-1:0]      row_index_i,
  input  logic [ppx_pkg::ColumnW-1:0]   column_index_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ppx_pkg::EnergyW-1:0]   energy_q8_i,
  input  logic [ppx_pkg::TimeW-1:0]     report_time_bin_i,
  input  logic                          report_low_gain_i,
  input  logic [ppx_pkg::ModuleW:0]     report_module_i,
  input  logic [ppx_pkg::RowW:0]        report_row_i,
  input  logic [ppx_pkg::ColumnW:0]     report_column_i,
  input  logic                          status_i,
  output int                            mismatches_o,
  output int                            reports_waiting_o,
  output int                            reports_seen_o,
  output int                            missing_ped_seen_o,
  output int                            saturated_seen_o
);
  import ppx_pkg::*;

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic [TimeW-1:0]   time_bin;
    logic               low_gain;
    logic [ModuleW:0]   module_no;
    logic [RowW:0]      row_no;
    logic [ColumnW:0]   col_no;
    logic               status;
  } channel_report_t;

  // register copies
  logic                 ped_on;
  logic [TimeW-1:0]     presample_lim;
  logic [GainW-1:0]     gain_factor;
  logic [BaselineW-1:0] baseline;

  // open channel
  logic                 holding;
  logic [SampleW-1:0]   peak;
  logic [SumW-1:0]      ped_sum;
  logic [CountW-1:0]    ped_count;
  logic [TimeW-1:0]     last_tbin;
  logic                 last_low_gain;
  logic [ModuleW-1:0]   last_module;
  logic [RowW-1:0]      last_row;
  logic [ColumnW-1:0]   last_col;

  channel_report_t expected_reports[$];

  function automatic channel_report_t close_channel();
    logic [63:0] peak_q8;
    logic [63:0] mean_q8;
    logic [63:0] e;
    channel_report_t r;
    peak_q8 = 64'(peak) << FracW;
    mean_q8 = '0;
    e = '0;
    r.status = 1'b0;
    if (ped_on && ped_count == 0) begin
      r.status = 1'b1;
    end else begin
      if (ped_on) mean_q8 = (64'(ped_sum) << FracW) / 64'(ped_count);
      e = (mean_q8 > peak_q8) ? 64'd0 : peak_q8 - mean_q8;
      if (last_low_gain) e = e * 64'(gain_factor);
      if (e < 64'(baseline)) e = '0;
      if (e > 64'(EnergyMax)) e = 64'(EnergyMax);
    end
    r.energy = e[EnergyW-1:0];
    r.time_bin = last_tbin;
    r.low_gain = last_low_gain;
    r.module_no = {1'b0, last_module} + (ModuleW+1)'(1);
    r.row_no = {1'b0, last_row} + (RowW+1)'(1);
    r.col_no = {1'b0, last_col} + (ColumnW+1)'(1);
    return r;
  endfunction

  task automatic take_sample();
    if (starts_channel_i && holding) expected_reports.push_back(close_channel());
    if (starts_channel_i || !holding) begin
      peak = sample_value_i;
      ped_sum = '0;
      ped_count = '0;
      holding = 1'b1;
    end else if (sample_value_i > peak) begin
      peak = sample_value_i;
    end
    last_tbin = time_bin_i;
    last_low_gain = low_gain_i;
    last_module = module_index_i;
    last_row = row_index_i;
    last_col = column_index_i;
    if (ped_on && time_bin_i < presample_lim && ped_count < MaxTimeBins) begin
      ped_sum = ped_sum + SumW'(sample_value_i);
      ped_count = ped_count + CountW'(1);
    end
  endtask

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  task automatic check_report();
    channel_report_t want;
    reports_seen_o++;
    if (status_i) missing_ped_seen_o++;
    if (energy_q8_i == EnergyMax) saturated_seen_o++;
    if (expected_reports.size() == 0) begin
      $error("report word with nothing expected: energy_q8 %0d", energy_q8_i);
      mismatches_o++;
    end else begin
      want = expected_reports.pop_front();
      match_field("energy_q8", want.energy, energy_q8_i);
      match_field("report_time_bin", want.time_bin, report_time_bin_i);
      match_field("report_low_gain", want.low_gain, report_low_gain_i);
      match_field("report_module", want.module_no, report_module_i);
      match_field("report_row", want.row_no, report_row_i);
      match_field("report_column", want.col_no, report_column_i);
      match_field("status", want.status, status_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_on = 1'b0;
      presample_lim = TimeW'(10);
      gain_factor = GainW'(16);
      baseline = BaselineW'(256);
      holding = 1'b0;
      peak = '0;
      ped_sum = '0;
      ped_count = '0;
      last_tbin = '0;
      last_low_gain = 1'b0;
      last_module = '0;
      last_row = '0;
      last_col = '0;
      expected_reports.delete();
      mismatches_o = 0;
      reports_seen_o = 0;
      missing_ped_seen_o = 0;
      saturated_seen_o = 0;
    end else begin
      // a sample in the same edge as a write still sees the old registers
      if (in_valid_i && in_ready_i) take_sample();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PED_ENABLE:    ped_on = cfg_data_i[0];
          CFG_PRESAMPLE_LIM: presample_lim = cfg_data_i[TimeW-1:0];
          CFG_LOW_GAIN_FACT: gain_factor = cfg_data_i[GainW-1:0];
          CFG_BASELINE:      baseline = cfg_data_i[BaselineW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_report();
    end
    reports_waiting_o = expected_reports.size();
  end

endmodule

FILE: tb/pulse_peak_pedestal_extractor_top_tb.sv
// testbench top: drives samples and register writes into the extractor and gives the verdict
`timescale 1ns / 1ps
module pulse_peak_pedestal_extractor_top_tb;
  import ppx_pkg::*;

  // settle time after the drain, long enough to cover one full report
  localparam int SettleCycles  = 40;
  // cycles with no word moving on any channel before the run is called hung
  localparam int StallLimit    = 2000;
  localparam int RandomSamples = 930;
  localparam int RandomPhases  = 8;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [TimeW-1:0]   tbin;
    logic               starts;
    logic               low_gain;
    logic [ModuleW-1:0] module_no;
    logic [RowW-1:0]    row_no;
    logic [ColumnW-1:0] col_no;
  } sample_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [SampleW-1:0]   sample_value_i;
  logic [TimeW-1:0]     time_bin_i;
  logic                 starts_channel_i;
  logic                 low_gain_i;
  logic [ModuleW-1:0]   module_index_i;
  logic [RowW-1:0]      row_index_i;
  logic [ColumnW-1:0]   column_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [EnergyW-1:0]   energy_q8_o;
  logic [TimeW-1:0]     report_time_bin_o;
  logic                 report_low_gain_o;
  logic [ModuleW:0]     report_module_o;
  logic [RowW:0]        report_row_o;
  logic [ColumnW:0]     report_column_o;
  logic                 status_o;

  int mismatches;
  int reports_waiting;
  int reports_seen;
  int missing_ped_seen;
  int saturated_seen;

  // stimulus bookkeeping for the summary
  int  samples_sent = 0;
  int  cfg_writes = 0;
  int  settings_used = 0;
  // when set, the sample side sends back to back
  bit  steady_sender = 1'b0;

  always #10 clk_i = ~clk_i;

  pulse_peak_pedestal_extractor_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_value_i    (sample_value_i),
    .time_bin_i        (time_bin_i),
    .starts_channel_i  (starts_channel_i),
    .low_gain_i        (low_gain_i),
    .module_index_i    (module_index_i),
    .row_index_i       (row_index_i),
    .column_index_i    (column_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .energy_q8_o       (energy_q8_o),
    .report_time_bin_o (report_time_bin_o),
    .report_low_gain_o (report_low_gain_o),
    .report_module_o   (report_module_o),
    .report_row_o      (report_row_o),
    .report_column_o   (report_column_o),
    .status_o          (status_o)
  );

  // prediction and comparison live here, the top only makes stimulus
  peak_report_checker report_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .sample_value_i     (sample_value_i),
    .time_bin_i         (time_bin_i),
    .starts_channel_i   (starts_channel_i),
    .low_gain_i         (low_gain_i),
    .module_index_i     (module_index_i),
    .row_index_i        (row_index_i),
    .column_index_i     (column_index_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .energy_q8_i        (energy_q8_o),
    .report_time_bin_i  (report_time_bin_o),
    .report_low_gain_i  (report_low_gain_o),
    .report_module_i    (report_module_o),
    .report_row_i       (report_row_o),
    .report_column_i    (report_column_o),
    .status_i           (status_o),
    .mismatches_o       (mismatches),
    .reports_waiting_o  (reports_waiting),
    .reports_seen_o     (reports_seen),
    .missing_ped_seen_o (missing_ped_seen),
    .saturated_seen_o   (saturated_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int next_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_word_t word_of(int value, int tbin, bit starts, bit lg,
                                           int mod_no, int row_no, int col_no);
    sample_word_t w;
    w.value = SampleW'(value);
    w.tbin = TimeW'(tbin);
    w.starts = starts;
    w.low_gain = lg;
    w.module_no = ModuleW'(mod_no);
    w.row_no = RowW'(row_no);
    w.col_no = ColumnW'(col_no);
    return w;
  endfunction

  // one register write; valid drops on the next falling edge
  task automatic cfg_write(cfg_index_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one sample word; called right after an edge, returns at the accepting edge
  // with zero gap valid simply stays high and only the payload changes
  task automatic push_sample(sample_word_t w);
    int gap;
    gap = next_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= w.value;
    time_bin_i <= w.tbin;
    starts_channel_i <= w.starts;
    low_gain_i <= w.low_gain;
    module_index_i <= w.module_no;
    row_index_i <= w.row_no;
    column_index_i <= w.col_no;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  // stop sending, let every pending report come out, then let the block settle
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports_waiting != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // writes all four registers; junk fills the data bits above each field
  task automatic apply_settings(bit ped, int lim, int fac, int base, bit junk);
    logic [CfgDataW-1:0] d;
    quiesce();
    d = junk ? CfgDataW'($urandom) : '0;
    d[0] = ped;
    cfg_write(CFG_PED_ENABLE, d);
    d = junk ? CfgDataW'($urandom) : '0;
    d[TimeW-1:0] = TimeW'(lim);
    cfg_write(CFG_PRESAMPLE_LIM, d);
    d = junk ? CfgDataW'($urandom) : '0;
    d[GainW-1:0] = GainW'(fac);
    cfg_write(CFG_LOW_GAIN_FACT, d);
    cfg_write(CFG_BASELINE, CfgDataW'(base));
    settings_used++;
  endtask

  // well-formed channels with random content, a share of noise words mixed in
  task automatic run_channels(int n_items, int noise_pct);
    int sent;
    int len;
    int base_tb;
    sample_word_t w;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
      // presamples sit at the start of a readout, so most channels start at low bins
      base_tb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
      w = word_of(0, 0, 1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 7),
                  $urandom_range(0, 63), $urandom_range(0, 63));
      for (int k = 0; k < len; k++) begin
        w.starts = (k == 0);
        w.value = $urandom_range(0, 1) ? SampleW'($urandom_range(0, 1023))
                                       : SampleW'($urandom_range(0, 63));
        w.tbin = TimeW'(base_tb + k);
        if ($urandom_range(0, 99) < noise_pct) begin
          w.starts = 1'($urandom_range(0, 1));
          w.tbin = TimeW'($urandom);
          w.low_gain = 1'($urandom_range(0, 1));
          w.module_no = ModuleW'($urandom);
          w.row_no = RowW'($urandom);
          w.col_no = ColumnW'($urandom);
        end
        push_sample(w);
        sent++;
      end
    end
  endtask

  // receiver: ready runs and stalls, mostly short, some long, some long open stretches
  initial begin : report_drain
    int mode;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 99);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      if (mode < 10) begin
        repeat ($urandom_range(100, 300)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ready_i <= 1'b0;
      if (mode < 90) repeat ($urandom_range(0, 2)) @(negedge clk_i);
      else repeat ($urandom_range(20, 60)) @(negedge clk_i);
    end
  end

  // hang detection: no word moved on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL pulse_peak_pedestal_extractor_top");
    $finish;
  end

  initial begin : stimulus
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PED_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_value_i = '0;
    time_bin_i = '0;
    starts_channel_i = 1'b0;
    low_gain_i = 1'b0;
    module_index_i = '0;
    row_index_i = '0;
    column_index_i = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: pedestal off, limit 10, factor 16, baseline 256
    // the very first word opens a channel whether marked or not; the seed picks which
    push_sample(word_of(5, 0, 1'($urandom_range(0, 1)), 1'b0, 0, 0, 0));
    push_sample(word_of(1023, 1, 1'b0, 1'b0, 0, 0, 0));
    // closes full-scale high gain; opens low gain at the top address
    push_sample(word_of(0, 1023, 1'b1, 1'b1, 7, 63, 63));
    push_sample(word_of(1023, 1023, 1'b0, 1'b1, 7, 63, 63));
    // closes full-scale low gain, scaled by 16 to just under the clamp
    push_sample(word_of(0, 0, 1'b1, 1'b0, 0, 0, 0));
    // closes a zero peak, below baseline
    push_sample(word_of(1, 0, 1'b1, 1'b0, 1, 2, 3));
    // closes a peak of one, landing exactly on the baseline
    push_sample(word_of(0, 5, 1'b1, 1'b0, 4, 5, 6));

    apply_settings(1'b1, 10, 16, 0, 1'b0);
    // the held channel has no presamples under pedestal mode
    push_sample(word_of(100, 20, 1'b1, 1'b0, 2, 2, 2));
    push_sample(word_of(200, 25, 1'b0, 1'b0, 2, 2, 2));
    // missing presamples again, and the next channel opens normally
    push_sample(word_of(7, 0, 1'b1, 1'b0, 3, 3, 3));
    push_sample(word_of(7, 9, 1'b0, 1'b0, 3, 3, 3));
    // first bin at the limit, not a presample
    push_sample(word_of(3, 10, 1'b0, 1'b0, 3, 3, 3));
    // closes with pedestal equal to peak, energy clamps to zero
    push_sample(word_of(2, 0, 1'b1, 1'b1, 5, 9, 17));
    push_sample(word_of(900, 3, 1'b0, 1'b1, 5, 9, 17));
    // closes low gain with pedestal subtraction
    push_sample(word_of(40, 30, 1'b1, 1'b0, 6, 40, 50));

    apply_settings(1'b1, 0, 0, 0, 1'b0);
    // limit zero: even bin 0 is no presample
    push_sample(word_of(500, 0, 1'b0, 1'b1, 6, 40, 50));
    push_sample(word_of(10, 1, 1'b1, 1'b1, 0, 63, 0));
    push_sample(word_of(300, 40, 1'b1, 1'b0, 0, 0, 63));

    apply_settings(1'b0, 10, 0, 0, 1'b0);
    push_sample(word_of(600, 2, 1'b1, 1'b1, 1, 1, 1));
    // closes a low gain channel under a zero factor
    push_sample(word_of(0, 0, 1'b1, 1'b0, 2, 3, 4));

    // random phases: fixed extremes first, then random register values
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: apply_settings(1'b1, 10, 16, 256, 1'b0);
        1: apply_settings(1'b0, 1, 64, 0, 1'b0);
        2: apply_settings(1'b1, 1023, 1, 262144, 1'b0);
        3: apply_settings(1'b1, 0, 127, 0, 1'b0);
        4: apply_settings(1'b1, 1, 64, 524287, 1'b0);
        default: begin
          apply_settings(1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                   : $urandom_range(1, 16),
                         $urandom_range(0, 127),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 524287)
                                                   : $urandom_range(0, 8192),
                         1'b1);
        end
      endcase
      // one phase runs the sample side flat out
      steady_sender = (p == 5);
      run_channels(RandomSamples / RandomPhases, 10);
    end
    steady_sender = 1'b0;

    // close the last open channel
    push_sample(word_of(2, 0, 1'b1, 1'b1, 7, 0, 63));

    // drain and let the block settle before the verdict
    quiesce();

    $display("run covered %0d samples, %0d register writes over %0d settings",
             samples_sent, cfg_writes, settings_used);
    $display("%0d reports compared: %0d with missing presamples, %0d at full scale",
             reports_seen, missing_ped_seen, saturated_seen);
    if (mismatches == 0 && reports_waiting == 0) begin
      $display("PASS pulse_peak_pedestal_extractor_top");
    end else begin
      $display("FAIL pulse_peak_pedestal_extractor_top");
    end
    $finish;
  end

endmodule
